/* rtl/rhn_pkg.sv */
// Shared types, constants and elaboration-time functions of the random hop noise NCO.
`default_nettype none

package rhn_pkg;

    // Datapath sizes.
    localparam int PHASE_BITS           = 32;
    localparam int SAMPLE_BITS          = 16;
    localparam int SINE_TABLE_ADDR_BITS = 10;

    localparam int QUARTER_ADDR_BITS = SINE_TABLE_ADDR_BITS - 2;
    localparam int QUARTER_ENTRIES   = 1 << QUARTER_ADDR_BITS;
    localparam int TAB_BITS          = 31;
    localparam int AMP_BITS          = 15;
    localparam int PROD_BITS         = AMP_BITS + TAB_BITS;
    localparam int OUT_SHIFT         = 46 - SAMPLE_BITS;
    localparam int MAG_BITS          = PROD_BITS + 1 - OUT_SHIFT;
    localparam int INDEX_BITS        = 24;
    localparam int BURST_BITS        = 25;
    localparam int CFG_INDEX_BITS    = 3;
    localparam int CFG_DATA_BITS     = 64;

    // Scaling of 2^32 phase values onto the accumulator width.
    localparam int PHASE_UP = (PHASE_BITS >= 32) ? PHASE_BITS - 32 : 0;
    localparam int PHASE_DN = (PHASE_BITS < 32) ? 32 - PHASE_BITS : 0;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH      = 2;
    localparam int QUEUE_PTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

    // Fixed numbers of the table build and the generator.
    localparam logic [63:0] PI_Q30          = 64'd3373259426;
    localparam logic [63:0] ONE_Q30         = 64'd1 << 30;
    localparam logic [63:0] ANGLE_DIV       = 64'(4 * QUARTER_ENTRIES);
    localparam logic [63:0] ZERO_SEED_SUBST = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [BURST_BITS-1:0] MAX_BURST = {1'b1, {(BURST_BITS - 1){1'b0}}};

    // Output scaling constants.
    localparam logic [PROD_BITS:0] ROUND_BIAS =
        {{PROD_BITS{1'b0}}, 1'b1} << (OUT_SHIFT - 1);
    localparam logic [SAMPLE_BITS-1:0] MAX_POS  = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

    // Register indexes of the configuration port.
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_CENTER      = 3'd0,
        CFG_HALF_SPAN   = 3'd1,
        CFG_AMP_MEAN    = 3'd2,
        CFG_AMP_SPAN    = 3'd3,
        CFG_START_PHASE = 3'd4,
        CFG_SEED        = 3'd5,
        CFG_BURST_LEN   = 3'd6
    } cfg_index_t;

    typedef logic [PHASE_BITS-1:0]           phase_t;
    typedef logic signed [SAMPLE_BITS-1:0]   sample_t;
    typedef logic [AMP_BITS-1:0]             amp_t;
    typedef logic [TAB_BITS-1:0]             tab_t;
    typedef logic [SINE_TABLE_ADDR_BITS-1:0] angle_t;

    typedef struct packed {
        logic [31:0]           center_increment;
        logic [30:0]           half_span_increment;
        logic [14:0]           amplitude_mean;
        logic [15:0]           amplitude_span;
        logic [31:0]           start_phase;
        logic [63:0]           generator_seed;
        logic [BURST_BITS-1:0] burst_length;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        center_increment:    32'd0,
        half_span_increment: 31'd0,
        amplitude_mean:      15'd16384,
        amplitude_span:      16'd0,
        start_phase:         32'd0,
        generator_seed:      64'd1,
        burst_length:        25'd1024
    };

    // One sample's work as handed from the front to the back.
    typedef struct packed {
        amp_t   amp;
        angle_t angle;
        logic   last;
    } job_t;

    // Maps a 2^32-scaled value onto the accumulator width.
    function automatic phase_t to_phase(input logic [31:0] v);
        logic [PHASE_BITS+31:0] w;
        w = {PHASE_BITS'(0), v} << PHASE_UP;
        w = w >> PHASE_DN;
        return w[PHASE_BITS-1:0];
    endfunction

    // One xorshift64 step.
    function automatic logic [63:0] xorshift64(input logic [63:0] s);
        logic [63:0] x;
        x = s ^ (s << 13);
        x = x ^ (x >> 7);
        x = x ^ (x << 17);
        return x;
    endfunction

    // Integer Taylor series of sine in Q1.30, evaluated at elaboration only.
    function automatic logic [63:0] sine_q30(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        term = ((term * x2) >> 30) / 64'd6;
        sum  = (sum > term) ? sum - term : 64'd0;
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd42;
        sum  = (sum > term) ? sum - term : 64'd0;
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd110;
        sum  = (sum > term) ? sum - term : 64'd0;
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd210;
        sum  = (sum > term) ? sum - term : 64'd0;
        term = ((term * x2) >> 30) / 64'd272;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd342;
        sum  = (sum > term) ? sum - term : 64'd0;
        if (sum > ONE_Q30)
        begin
            sum = ONE_Q30;
        end
        return sum;
    endfunction

    // Quarter-wave entry k: sine at the centre of the k-th slot.
    function automatic tab_t sine_entry(input int unsigned k);
        logic [63:0] ang;
        ang = (64'(2 * k + 1) * PI_Q30) / ANGLE_DIV;
        return tab_t'(sine_q30(ang));
    endfunction

endpackage

`default_nettype wire

/* rtl/rhn_if.sv */
// Handshake channels of the random hop noise NCO: request items in, samples out.
`default_nettype none

interface rhn_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface rhn_out_if;
    logic             valid;
    logic             ready;
    rhn_pkg::sample_t in_phase;
    rhn_pkg::sample_t quadrature;
    logic             last_of_burst;

    modport source (output valid, output in_phase, output quadrature,
                    output last_of_burst, input ready);
    modport sink   (input valid, input in_phase, input quadrature,
                    input last_of_burst, output ready);
endinterface

`default_nettype wire

/* rtl/random_hop_noise_nco_unit.sv */
// Random frequency hopping NCO noise source.
// Each transfer on the request channel asks for one complex baseband sample;
// its restart bit reloads the phase, the generator and the sample index first.
// Each sample comes out as one transfer on the sample channel carrying in_phase,
// quadrature and last_of_burst, in request order.
// The configuration port writes one register per cycle while cfg_we is high:
// centre and half span of the phase increment, amplitude mean and span, start
// phase, generator seed and burst length. New start phase and seed values apply
// at the next reload; a new burst length takes effect at once.
// The front sequencer takes one request at a time: it draws the random
// numbers, scales them through its multiplier and then steps the phase
// accumulator before it takes the next request. A sample then passes the job
// queue and the lookup, multiply and output registers of the back.
// When the receiver stalls, the output register holds its sample, the back
// pipeline stops, the two-entry job queue fills and the request channel drops
// ready; nothing is lost.
// Reset puts the configuration, state, pointer and valid registers at their
// reset values and loads the phase from the start phase, the generator from
// the seed and the index with zero; the data registers are not reset.
`default_nettype none

module random_hop_noise_nco_unit (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [rhn_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [rhn_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    rhn_in_if.sink                                  request,
    rhn_out_if.source                               sample
);

    rhn_pkg::cfg_t cfg_reg, cfg_next;

    logic          push_valid;
    logic          push_ready;
    rhn_pkg::job_t push_data;
    logic          pop_valid;
    logic          pop_ready;
    rhn_pkg::job_t pop_data;

    // Configuration register writes.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                rhn_pkg::CFG_CENTER:      cfg_next.center_increment    = cfg_data[31:0];
                rhn_pkg::CFG_HALF_SPAN:   cfg_next.half_span_increment = cfg_data[30:0];
                rhn_pkg::CFG_AMP_MEAN:    cfg_next.amplitude_mean      = cfg_data[14:0];
                rhn_pkg::CFG_AMP_SPAN:    cfg_next.amplitude_span      = cfg_data[15:0];
                rhn_pkg::CFG_START_PHASE: cfg_next.start_phase         = cfg_data[31:0];
                rhn_pkg::CFG_SEED:        cfg_next.generator_seed      = cfg_data[63:0];
                rhn_pkg::CFG_BURST_LEN:
                begin
                    cfg_next.burst_length = cfg_data[rhn_pkg::BURST_BITS-1:0];
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= rhn_pkg::CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    rhn_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .request    (request),
        .cfg        (cfg_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    rhn_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    rhn_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data),
        .sample     (sample)
    );

endmodule

`default_nettype wire

/* rtl/rhn_front.sv */
// Front of the NCO: takes requests, draws the random numbers and steps the phase.
`default_nettype none

module rhn_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    rhn_in_if.sink             request,
    input  wire rhn_pkg::cfg_t cfg,
    output logic               push_valid,
    input  wire logic          push_ready,
    output rhn_pkg::job_t      push_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_UPD
    } state_t;

    state_t                             state_reg, state_next;
    rhn_pkg::phase_t                    phase_reg, phase_next;
    logic [63:0]                        rand_reg, rand_next;
    logic [rhn_pkg::INDEX_BITS-1:0]     index_reg, index_next;
    logic [31:0]                        u_inc_reg, u_inc_next;
    logic [31:0]                        u_amp_reg, u_amp_next;
    logic [31:0]                        off_inc_reg, off_inc_next;
    logic [15:0]                        off_amp_reg, off_amp_next;

    logic [63:0]                        seed_eff;
    rhn_pkg::phase_t                    start_ph;
    rhn_pkg::phase_t                    base_phase;
    logic [63:0]                        base_rand;
    logic [rhn_pkg::INDEX_BITS-1:0]     base_index;
    logic [63:0]                        draw1;
    logic [63:0]                        draw2;
    logic [31:0]                        half_span_x2p1;
    logic [16:0]                        span_p1;
    logic [63:0]                        mul_inc;
    logic [48:0]                        mul_amp;
    logic [31:0]                        inc;
    logic signed [17:0]                 amp_wide;
    rhn_pkg::amp_t                      amp;
    logic [rhn_pkg::BURST_BITS-1:0]     len;
    logic                               last;

    // Reload values and the two generator steps of a new sample.
    always_comb
    begin
        seed_eff   = (cfg.generator_seed == 64'd0) ? rhn_pkg::ZERO_SEED_SUBST
                                                    : cfg.generator_seed;
        start_ph   = rhn_pkg::to_phase(cfg.start_phase);
        base_phase = request.restart ? start_ph : phase_reg;
        base_rand  = request.restart ? seed_eff : rand_reg;
        base_index = request.restart ? '0 : index_reg;
        draw1      = rhn_pkg::xorshift64(base_rand);
        draw2      = rhn_pkg::xorshift64(draw1);
    end

    // Scaling of the two draws onto their ranges.
    always_comb
    begin
        half_span_x2p1 = {cfg.half_span_increment, 1'b1};
        span_p1        = {1'b0, cfg.amplitude_span} + 17'd1;
        mul_inc        = u_inc_reg * half_span_x2p1;
        mul_amp        = u_amp_reg * span_p1;
    end

    // Increment, clamped amplitude and end of burst.
    always_comb
    begin
        inc      = cfg.center_increment + off_inc_reg - {1'b0, cfg.half_span_increment};
        amp_wide = $signed({3'b000, cfg.amplitude_mean}) + $signed({2'b00, off_amp_reg})
                 - $signed({3'b000, cfg.amplitude_span[15:1]});
        if (amp_wide < 0)
        begin
            amp = '0;
        end
        else if (amp_wide > 18'sd32767)
        begin
            amp = '1;
        end
        else
        begin
            amp = amp_wide[rhn_pkg::AMP_BITS-1:0];
        end
        if (cfg.burst_length == '0)
        begin
            len = rhn_pkg::BURST_BITS'(1);
        end
        else if (cfg.burst_length > rhn_pkg::MAX_BURST)
        begin
            len = rhn_pkg::MAX_BURST;
        end
        else
        begin
            len = cfg.burst_length;
        end
        last = {1'b0, index_reg} >= (len - rhn_pkg::BURST_BITS'(1));
    end

    assign request.ready = (state_reg == S_IDLE);
    assign push_valid    = (state_reg == S_UPD);
    assign push_data     = '{amp: amp,
                             angle: phase_reg[rhn_pkg::PHASE_BITS-1 -:
                                              rhn_pkg::SINE_TABLE_ADDR_BITS],
                             last: last};

    // Sequencer: accept, scale the draws, then hand the job on and step the state.
    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        rand_next    = rand_reg;
        index_next   = index_reg;
        u_inc_next   = u_inc_reg;
        u_amp_next   = u_amp_reg;
        off_inc_next = off_inc_reg;
        off_amp_next = off_amp_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (request.valid)
                begin
                    phase_next = base_phase;
                    rand_next  = draw2;
                    index_next = base_index;
                    u_inc_next = draw1[63:32];
                    u_amp_next = draw2[63:32];
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                off_inc_next = mul_inc[63:32];
                off_amp_next = mul_amp[47:32];
                state_next   = S_UPD;
            end
            S_UPD:
            begin
                if (push_ready)
                begin
                    if (last)
                    begin
                        phase_next = start_ph;
                        rand_next  = seed_eff;
                        index_next = '0;
                    end
                    else
                    begin
                        phase_next = phase_reg + rhn_pkg::to_phase(inc);
                        index_next = index_reg + rhn_pkg::INDEX_BITS'(1);
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and generator registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= rhn_pkg::to_phase(rhn_pkg::CFG_RESET.start_phase);
            rand_reg  <= rhn_pkg::CFG_RESET.generator_seed;
            index_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            rand_reg  <= rand_next;
            index_reg <= index_next;
        end
    end

    // Draw and product registers.
    always_ff @(posedge clk)
    begin
        u_inc_reg   <= u_inc_next;
        u_amp_reg   <= u_amp_next;
        off_inc_reg <= off_inc_next;
        off_amp_reg <= off_amp_next;
    end

`ifndef SYNTHESIS
    a_accept_starts_draw: assert property (@(posedge clk) disable iff (!rst_n)
        (request.valid && request.ready) |=> (state_reg == S_MUL))
        else $error("accepted request did not start the draw step");

    a_burst_reload: assert property (@(posedge clk) disable iff (!rst_n)
        (push_valid && push_ready && push_data.last)
            |=> (index_reg == '0 && phase_reg == $past(start_ph)))
        else $error("end of burst did not reload phase and index");

    a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPD && !push_ready)
            |=> (state_reg == S_UPD && $stable(phase_reg) && $stable(rand_reg)))
        else $error("state moved while the queue was full");
`endif

endmodule

`default_nettype wire

/* rtl/rhn_queue.sv */
// Short first-in first-out queue of sample jobs between the front and the back.
`default_nettype none

module rhn_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push_valid,
    output logic               push_ready,
    input  wire rhn_pkg::job_t push_data,
    output logic               pop_valid,
    input  wire logic          pop_ready,
    output rhn_pkg::job_t      pop_data
);

    rhn_pkg::job_t                         entries [rhn_pkg::QUEUE_DEPTH];
    logic [rhn_pkg::QUEUE_PTR_BITS-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [rhn_pkg::QUEUE_PTR_BITS-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [rhn_pkg::QUEUE_COUNT_BITS-1:0]  count_reg, count_next;
    logic                                  do_push;
    logic                                  do_pop;

    assign push_ready = (count_reg != rhn_pkg::QUEUE_COUNT_BITS'(rhn_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entries[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == rhn_pkg::QUEUE_PTR_BITS'(rhn_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + rhn_pkg::QUEUE_PTR_BITS'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == rhn_pkg::QUEUE_PTR_BITS'(rhn_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + rhn_pkg::QUEUE_PTR_BITS'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + rhn_pkg::QUEUE_COUNT_BITS'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - rhn_pkg::QUEUE_COUNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

/* rtl/rhn_back.sv */
// Back of the NCO: quarter-wave lookup, amplitude multiply, rounding and output register.
`default_nettype none

module rhn_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          pop_valid,
    output logic               pop_ready,
    input  wire rhn_pkg::job_t pop_data,
    rhn_out_if.source          sample
);

    rhn_pkg::tab_t quarter_tab [rhn_pkg::QUARTER_ENTRIES];

    logic                                   advance;
    logic [1:0]                             quad;
    logic [rhn_pkg::QUARTER_ADDR_BITS-1:0]  idx;
    logic [rhn_pkg::QUARTER_ADDR_BITS-1:0]  idx_rev;

    logic                       s1_valid_reg;
    rhn_pkg::amp_t              s1_amp_reg;
    rhn_pkg::tab_t              s1_sin_reg;
    rhn_pkg::tab_t              s1_cos_reg;
    logic                       s1_sin_neg_reg;
    logic                       s1_cos_neg_reg;
    logic                       s1_last_reg;

    logic                       s2_valid_reg;
    logic [rhn_pkg::PROD_BITS-1:0] s2_sin_prod_reg;
    logic [rhn_pkg::PROD_BITS-1:0] s2_cos_prod_reg;
    logic                       s2_sin_neg_reg;
    logic                       s2_cos_neg_reg;
    logic                       s2_last_reg;

    logic                       out_valid_reg;
    rhn_pkg::sample_t           in_phase_reg;
    rhn_pkg::sample_t           quadrature_reg;
    logic                       last_reg;

    // Rounds, saturates and signs one product.
    function automatic rhn_pkg::sample_t scale_out(
        input logic [rhn_pkg::PROD_BITS-1:0] prod,
        input logic                          neg
    );
        logic [rhn_pkg::PROD_BITS:0]       rounded;
        logic [rhn_pkg::MAG_BITS-1:0]      mag;
        logic [rhn_pkg::SAMPLE_BITS-1:0]   sat;
        rounded = {1'b0, prod} + rhn_pkg::ROUND_BIAS;
        mag     = rounded[rhn_pkg::PROD_BITS:rhn_pkg::OUT_SHIFT];
        sat     = (mag > rhn_pkg::MAG_BITS'(rhn_pkg::MAX_POS))
                ? rhn_pkg::MAX_POS : mag[rhn_pkg::SAMPLE_BITS-1:0];
        return neg ? $signed(-sat) : $signed(sat);
    endfunction

    // Quarter-wave sine table, fixed at elaboration.
    for (genvar k = 0; k < rhn_pkg::QUARTER_ENTRIES; k++)
    begin : g_tab
        assign quarter_tab[k] = rhn_pkg::sine_entry(k);
    end

    // The whole pipe moves when the output register is free or being emptied.
    assign advance   = !out_valid_reg || sample.ready;
    assign pop_ready = advance;

    assign quad    = pop_data.angle[rhn_pkg::SINE_TABLE_ADDR_BITS-1 -: 2];
    assign idx     = pop_data.angle[rhn_pkg::QUARTER_ADDR_BITS-1:0];
    assign idx_rev = ~idx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= pop_valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    // Lookup stage, multiply stage and output stage.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_amp_reg      <= pop_data.amp;
            s1_sin_reg      <= quad[0] ? quarter_tab[idx_rev] : quarter_tab[idx];
            s1_cos_reg      <= quad[0] ? quarter_tab[idx] : quarter_tab[idx_rev];
            s1_sin_neg_reg  <= quad[1];
            s1_cos_neg_reg  <= quad[1] ^ quad[0];
            s1_last_reg     <= pop_data.last;

            s2_sin_prod_reg <= s1_amp_reg * s1_sin_reg;
            s2_cos_prod_reg <= s1_amp_reg * s1_cos_reg;
            s2_sin_neg_reg  <= s1_sin_neg_reg;
            s2_cos_neg_reg  <= s1_cos_neg_reg;
            s2_last_reg     <= s1_last_reg;

            in_phase_reg    <= scale_out(s2_cos_prod_reg, s2_cos_neg_reg);
            quadrature_reg  <= scale_out(s2_sin_prod_reg, s2_sin_neg_reg);
            last_reg        <= s2_last_reg;
        end
    end

    assign sample.valid         = out_valid_reg;
    assign sample.in_phase      = in_phase_reg;
    assign sample.quadrature    = quadrature_reg;
    assign sample.last_of_burst = last_reg;

`ifndef SYNTHESIS
    a_in_phase_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        sample.valid |-> (sample.in_phase != $signed(rhn_pkg::MOST_NEG)))
        else $error("in-phase sample escaped saturation");

    a_quadrature_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        sample.valid |-> (sample.quadrature != $signed(rhn_pkg::MOST_NEG)))
        else $error("quadrature sample escaped saturation");
`endif

endmodule

`default_nettype wire
